// File: design/cdbr_pkg.sv
package cdbr_pkg;

    // Widths of the event fields and the configuration registers.
    localparam int COORD_BITS    = 16;
    localparam int MODIFIER_KEYS = 8;
    localparam int TIME_BITS     = 32;
    localparam int LIMIT_BITS    = 16;
    localparam int RADIUS_BITS   = 8;
    localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS;
    localparam int BUTTON_BITS   = 3;
    localparam int TRIGGER_BITS  = 2;
    localparam int MODE_BITS     = 2;
    localparam int INJECT_BITS   = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_INDEX_BITS = 3;

    // Event kinds.
    localparam logic [MODE_BITS-1:0] MODE_MOVE  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DOWN  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_UP    = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_OTHER = 2'd3;

    // Injection requests.
    localparam logic [INJECT_BITS-1:0] INJECT_NONE   = 2'd0;
    localparam logic [INJECT_BITS-1:0] INJECT_SOURCE = 2'd1;
    localparam logic [INJECT_BITS-1:0] INJECT_RIGHT  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLED         = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PASS_FOREIGN    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLICK_TIME      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_RADIUS     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_BUTTON  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REQUIRED_MODS   = 3'd5;

    // Register values after reset.
    localparam logic [LIMIT_BITS-1:0]     RESET_CLICK_TIME = 16'd250;
    localparam logic [RADIUS_BITS-1:0]    RESET_RADIUS     = 8'd6;
    localparam logic [MODIFIER_KEYS-1:0]  RESET_MODS       = MODIFIER_KEYS'(1);

    typedef struct packed {
        logic                           is_action;
        logic [MODE_BITS-1:0]           mode;
        logic [BUTTON_BITS-1:0]         button;
        logic signed [COORD_BITS-1:0]   pos_x;
        logic signed [COORD_BITS-1:0]   pos_y;
        logic [TIME_BITS-1:0]           time_ms;
        logic                           own_tag;
        logic                           injected;
        logic [MODIFIER_KEYS-1:0]       modifiers_held;
    } event_t;

    typedef struct packed {
        logic                           enabled;
        logic                           pass_foreign;
        logic [LIMIT_BITS-1:0]          click_time_limit;
        logic [RADIUS_SQ_BITS-1:0]      radius_sq;
        logic [TRIGGER_BITS-1:0]        trigger_button;
        logic [MODIFIER_KEYS-1:0]       required_modifiers;
    } cfg_t;

    typedef struct packed {
        logic                           tracking;
        logic [COORD_BITS-1:0]          start_x;
        logic [COORD_BITS-1:0]          start_y;
        logic [TIME_BITS-1:0]           down_time;
    } track_t;

    typedef struct packed {
        logic                           consume;
        logic [INJECT_BITS-1:0]         inject;
        logic [TRIGGER_BITS-1:0]        inject_button;
    } result_t;

endpackage

// File: design/cdbr_decide.sv
module cdbr_decide
    import cdbr_pkg::*;
(
    input  event_t  ev,
    input  cfg_t    cfg,
    input  track_t  cur,
    output result_t res,
    output track_t  nxt
);

    // Magnitude of the difference of two signed coordinates; it always fits
    // in COORD_BITS bits as an unsigned number.
    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + (COORD_BITS+1)'(1)) : d;
        return m[COORD_BITS-1:0];
    endfunction

    logic [COORD_BITS-1:0]     mag_x;
    logic [COORD_BITS-1:0]     mag_y;
    logic                      far_x;
    logic                      far_y;
    logic [RADIUS_SQ_BITS-1:0] sq_x;
    logic [RADIUS_SQ_BITS-1:0] sq_y;
    logic [RADIUS_SQ_BITS:0]   sq_sum;
    logic                      beyond;
    logic [TIME_BITS-1:0]      elapsed;
    logic                      in_time;
    logic                      passes;
    logic                      is_trigger;
    logic                      mods_ok;

    assign mag_x = abs_diff(ev.pos_x, cur.start_x);
    assign mag_y = abs_diff(ev.pos_y, cur.start_y);

    // Any axis beyond the largest possible radius is outside the circle, so
    // the squares only need the low RADIUS_BITS of each magnitude.
    assign far_x  = mag_x > COORD_BITS'({RADIUS_BITS{1'b1}});
    assign far_y  = mag_y > COORD_BITS'({RADIUS_BITS{1'b1}});
    assign sq_x   = RADIUS_SQ_BITS'(mag_x[RADIUS_BITS-1:0])
                    * RADIUS_SQ_BITS'(mag_x[RADIUS_BITS-1:0]);
    assign sq_y   = RADIUS_SQ_BITS'(mag_y[RADIUS_BITS-1:0])
                    * RADIUS_SQ_BITS'(mag_y[RADIUS_BITS-1:0]);
    assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
    assign beyond = far_x || far_y || (sq_sum > {1'b0, cfg.radius_sq});

    // The tick wraps, so the elapsed time is taken modulo 2^TIME_BITS.
    assign elapsed = ev.time_ms - cur.down_time;
    assign in_time = elapsed <= TIME_BITS'(cfg.click_time_limit);

    assign passes = !ev.is_action || !cfg.enabled || ev.own_tag
                    || (cfg.pass_foreign && ev.injected);
    assign is_trigger = ev.button == {1'b0, cfg.trigger_button};
    assign mods_ok = (ev.modifiers_held & cfg.required_modifiers)
                     == cfg.required_modifiers;

    always_comb
    begin
        res.consume       = 1'b0;
        res.inject        = INJECT_NONE;
        res.inject_button = '0;
        nxt               = cur;
        if (!passes)
        begin
            case (ev.mode)
                MODE_DOWN:
                begin
                    if (is_trigger && mods_ok)
                    begin
                        nxt.tracking  = 1'b1;
                        nxt.start_x   = ev.pos_x;
                        nxt.start_y   = ev.pos_y;
                        nxt.down_time = ev.time_ms;
                        res.consume   = 1'b1;
                    end
                end
                MODE_MOVE:
                begin
                    if (cur.tracking && beyond)
                    begin
                        res.inject        = INJECT_SOURCE;
                        res.inject_button = cfg.trigger_button;
                        nxt.tracking      = 1'b0;
                    end
                end
                MODE_UP:
                begin
                    if (is_trigger && cur.tracking)
                    begin
                        if (in_time && !beyond)
                        begin
                            res.inject = INJECT_RIGHT;
                        end
                        nxt.tracking = 1'b0;
                        res.consume  = 1'b1;
                    end
                end
                default:
                begin
                    res.consume = 1'b0;
                end
            endcase
        end
    end

endmodule

// File: design/click_drag_button_remapper.sv
// Click-to-right-click remapper for a stream of pointer events.
//
// Input channel: one pointer event per request on in_valid / in_ready. Output
// channel: exactly one result per event on out_valid / out_ready, telling the
// host whether to swallow the event and what to inject in its place.
// Configuration: cfg_we writes cfg_data into the register at cfg_index in the
// same cycle; writes are expected only while no request is in flight.
//
// Pipeline: an accepted request enters the input register, and its result then
// moves into the result register once that is free, which raises out_valid.
// Throughput is one request per cycle while out_ready keeps the result register
// draining; the rate is set by the single combinational pass that both reads
// and updates the tracking state.
//
// Reset clears the tracking state and loads the register defaults: enabled,
// injected events ignored, 250 ms click time, 6 pixel radius, button 0 as
// trigger and modifier bit 0 required.
// When the receiver stalls, the result is held and the input register keeps
// one more request; in_ready drops only when both stages are full.
module click_drag_button_remapper
    import cdbr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          is_action,
    input  logic [MODE_BITS-1:0]          mode,
    input  logic [BUTTON_BITS-1:0]        button,
    input  logic signed [COORD_BITS-1:0]  pos_x,
    input  logic signed [COORD_BITS-1:0]  pos_y,
    input  logic [TIME_BITS-1:0]          time_ms,
    input  logic                          own_tag,
    input  logic                          injected,
    input  logic [MODIFIER_KEYS-1:0]      modifiers_held,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          consume,
    output logic [INJECT_BITS-1:0]        inject,
    output logic [TRIGGER_BITS-1:0]       inject_button,

    input  logic                          cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    cfg_t    cfg_reg;
    event_t  ev_reg;
    logic    ev_valid_reg;
    track_t  track_reg;
    track_t  track_next;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    advance;

    // Configuration registers. The radius is stored only as its square, so
    // the distance compare needs no extra multiplier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled            <= 1'b1;
            cfg_reg.pass_foreign       <= 1'b1;
            cfg_reg.click_time_limit   <= RESET_CLICK_TIME;
            cfg_reg.radius_sq          <= RADIUS_SQ_BITS'(RESET_RADIUS)
                                          * RADIUS_SQ_BITS'(RESET_RADIUS);
            cfg_reg.trigger_button     <= '0;
            cfg_reg.required_modifiers <= RESET_MODS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLED:
                    cfg_reg.enabled <= cfg_data[0];
                CFG_PASS_FOREIGN:
                    cfg_reg.pass_foreign <= cfg_data[0];
                CFG_CLICK_TIME:
                    cfg_reg.click_time_limit <= cfg_data[LIMIT_BITS-1:0];
                CFG_MOVE_RADIUS:
                    cfg_reg.radius_sq <= RADIUS_SQ_BITS'(cfg_data[RADIUS_BITS-1:0])
                                         * RADIUS_SQ_BITS'(cfg_data[RADIUS_BITS-1:0]);
                CFG_TRIGGER_BUTTON:
                    cfg_reg.trigger_button <= cfg_data[TRIGGER_BITS-1:0];
                CFG_REQUIRED_MODS:
                    cfg_reg.required_modifiers <= MODIFIER_KEYS'(cfg_data);
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The result register moves whenever it is empty or being drained; the
    // input register then hands its request over in the same cycle.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !ev_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            ev_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ev_reg.is_action      <= is_action;
            ev_reg.mode           <= mode;
            ev_reg.button         <= button;
            ev_reg.pos_x          <= pos_x;
            ev_reg.pos_y          <= pos_y;
            ev_reg.time_ms        <= time_ms;
            ev_reg.own_tag        <= own_tag;
            ev_reg.injected       <= injected;
            ev_reg.modifiers_held <= modifiers_held;
        end
    end

    cdbr_decide u_decide (
        .ev  (ev_reg),
        .cfg (cfg_reg),
        .cur (track_reg),
        .res (res_next),
        .nxt (track_next)
    );

    // The tracking state changes exactly when a request leaves the input
    // register, so the next request always sees its predecessor's update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ev_valid_reg;
            if (ev_valid_reg)
            begin
                track_reg <= track_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ev_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign consume       = res_reg.consume;
    assign inject        = res_reg.inject;
    assign inject_button = res_reg.inject_button;

    // A drag that leaves the radius injects the press but never swallows the move.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.inject == INJECT_SOURCE |-> !res_reg.consume)
        else $error("source press injected on a swallowed event");

    // A right click is only requested on a swallowed trigger release.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.inject == INJECT_RIGHT |-> res_reg.consume)
        else $error("right click requested without swallowing the release");

    // The injected button is only named for a source-button injection.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.inject_button != '0
        |-> res_reg.inject == INJECT_SOURCE)
        else $error("inject_button set without a source-button injection");

    // With the result register empty the block always takes a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled while the result register is empty");

endmodule
